// ----- hdl/first_fit_block_allocator_defines.svh -----
// ----------------------------------------------------------------------------
// first_fit_block_allocator_defines
// Assertion macros shared by the allocator RTL. Expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define FFBA_AST_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FFBA_AST_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/ffba_pkg.sv -----
// ----------------------------------------------------------------------------
// ffba_pkg
// Field widths and command codes of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

    localparam int REQ_W   = 13;
    localparam int ADDR_W  = 14;
    localparam int NEED_W  = 14;
    localparam int PAGES_W = 3;
    localparam int CNT_W   = 10;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

endpackage

// ----- hdl/ffba_if.sv -----
// ----------------------------------------------------------------------------
// ffba_if
// Request and response channels of the allocator (valid/ready beats).
// ----------------------------------------------------------------------------
interface ffba_req_if;
    logic                         valid;
    logic                         ready;
    logic                         cmd;
    logic [ffba_pkg::REQ_W-1:0]   req_size;
    logic [ffba_pkg::ADDR_W-1:0]  free_addr;

    modport source (output valid, output cmd, output req_size, output free_addr,
                    input ready);
    modport sink   (input valid, input cmd, input req_size, input free_addr,
                    output ready);
endinterface

interface ffba_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          ok;
    logic [ffba_pkg::ADDR_W-1:0]   addr;
    logic [ffba_pkg::PAGES_W-1:0]  pages_in_use;
    logic [ffba_pkg::CNT_W-1:0]    free_blocks;
    logic [ffba_pkg::CNT_W-1:0]    used_blocks;

    modport source (output valid, output ok, output addr, output pages_in_use,
                    output free_blocks, output used_blocks, input ready);
    modport sink   (input valid, input ok, input addr, input pages_in_use,
                    input free_blocks, input used_blocks, output ready);
endinterface

// ----- hdl/ffba_seg_ram.sv -----
// ----------------------------------------------------------------------------
// ffba_seg_ram
// Segment table store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ffba_seg_ram #(
    parameter int AW = 9,
    parameter int DW = 25
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hdl/first_fit_block_allocator.sv -----
// Sequence: an alloc visits segments page by page, claims a new page when none fits,
//   and shifts the later segments up on a split; an applied free scans pages, then
//   segments, checks the segment that follows, and shifts segments down for each
//   merge; an oversize alloc or a null free goes straight to the response.
// Throughput: one beat in flight; the next request is taken once the response
//   is registered.
// Reset: async rst_n clears counts and page count; RAM contents are not cleared,
//   only entries below each page's segment count are ever read.
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit variable-size allocator with split and coalescing over a segment RAM.
// ----------------------------------------------------------------------------
module first_fit_block_allocator #(
    parameter int PAGE_BYTES    = 4096,
    parameter int MAX_PAGES     = 4,
    parameter int BLOCK_HDR     = 24,
    parameter int PAGE_HDR      = 16,
    parameter int SEGS_PER_PAGE = 128
) (
    input  logic      clk,
    input  logic      rst_n,
    ffba_req_if.sink  req,
    ffba_rsp_if.source rsp
);

`include "first_fit_block_allocator_defines.svh"

    localparam int OW  = $clog2(PAGE_BYTES);
    localparam int EW  = 2 * OW + 1;
    localparam int NW  = ffba_pkg::NEED_W;
    localparam int XW  = ((OW > NW) ? OW : NW) + 2;
    localparam int PW  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int PCW = $clog2(MAX_PAGES + 1);
    localparam int SW  = $clog2(SEGS_PER_PAGE);
    localparam int CW  = $clog2(SEGS_PER_PAGE + 1);
    localparam int BW0 = $clog2(MAX_PAGES * PAGE_BYTES) + 1;
    localparam int BW  = (BW0 > ffba_pkg::ADDR_W) ? BW0 : ffba_pkg::ADDR_W + 1;
    localparam int AW  = PW + SW;
    localparam int ADW = ffba_pkg::ADDR_W;
    localparam int KW  = ffba_pkg::CNT_W;

    localparam logic [XW-1:0] HDR_X   = XW'(BLOCK_HDR);
    localparam logic [XW-1:0] CAP_X   = XW'(PAGE_BYTES - PAGE_HDR);
    localparam logic [XW-1:0] SPLIT_X = XW'(BLOCK_HDR + 8);
    localparam logic [BW-1:0] PB_B    = BW'(PAGE_BYTES);

    typedef enum logic [17:0] {
        S_IDLE     = 18'h00001,
        S_A_ISS    = 18'h00002,
        S_A_CHK    = 18'h00004,
        S_NEWPG    = 18'h00008,
        S_MV_CHK   = 18'h00010,
        S_MV_WR    = 18'h00020,
        S_SPLIT_HI = 18'h00040,
        S_SPLIT_LO = 18'h00080,
        S_F_PG     = 18'h00100,
        S_F_ISS    = 18'h00200,
        S_F_CHK    = 18'h00400,
        S_F_NISS   = 18'h00800,
        S_F_NCHK   = 18'h01000,
        S_F_WCUR   = 18'h02000,
        S_F_PREV   = 18'h04000,
        S_RM_CHK   = 18'h08000,
        S_RM_WR    = 18'h10000,
        S_DONE     = 18'h20000
    } state_t;

    function automatic logic [AW-1:0] seg_addr(input logic [PW-1:0] p,
                                               input logic [CW-1:0] i);
        return {p, i[SW-1:0]};
    endfunction

    // control state
    state_t           state_reg, state_next;
    logic [PCW-1:0]   page_count_reg, page_count_next;
    logic [BW-1:0]    pc_base_reg, pc_base_next;
    logic [KW-1:0]    free_cnt_reg, free_cnt_next;
    logic [KW-1:0]    used_cnt_reg, used_cnt_next;
    logic [CW-1:0]    segn_reg [MAX_PAGES];
    logic [CW-1:0]    segn_next [MAX_PAGES];
    logic             rsp_valid_reg, rsp_valid_next;
    logic             nm_reg, nm_next;
    logic             rm_last_reg, rm_last_next;

    // working payload
    logic [NW-1:0]    need_reg, need_next;
    logic [ADW-1:0]   fa_reg, fa_next;
    logic [PW-1:0]    pg_reg, pg_next;
    logic [BW-1:0]    base_reg, base_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic [CW-1:0]    j_reg, j_next;
    logic [EW-1:0]    cur_reg, cur_next;
    logic [EW-1:0]    prev_reg, prev_next;
    logic [OW-1:0]    foff_reg, foff_next;
    logic             ok_reg, ok_next;
    logic [ADW-1:0]   res_addr_reg, res_addr_next;
    logic             rsp_ok_reg, rsp_ok_next;
    logic [ADW-1:0]   rsp_addr_reg, rsp_addr_next;
    logic [PCW-1:0]   rsp_pages_reg, rsp_pages_next;
    logic [KW-1:0]    rsp_free_reg, rsp_free_next;
    logic [KW-1:0]    rsp_used_reg, rsp_used_next;

    // segment RAM
    logic             mem_we, mem_re;
    logic [AW-1:0]    mem_waddr, mem_raddr;
    logic [EW-1:0]    mem_wdata, mem_rdata;

    ffba_seg_ram #(
        .AW (AW),
        .DW (EW)
    ) u_seg_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    logic [OW-1:0]    e_off, e_size, cur_off, cur_size, prev_off, prev_size, off_sel;
    logic             e_free, prev_free;
    logic [CW-1:0]    n_cur, idx_inc, j_inc, j_dec;
    logic [XW-1:0]    need_x, e_size_x;
    logic [NW-1:0]    need_w;
    logic [BW-1:0]    addr_full, fa_b, base_end;

    assign e_off     = mem_rdata[OW-1:0];
    assign e_size    = mem_rdata[2*OW-1:OW];
    assign e_free    = mem_rdata[2*OW];
    assign cur_off   = cur_reg[OW-1:0];
    assign cur_size  = cur_reg[2*OW-1:OW];
    assign prev_off  = prev_reg[OW-1:0];
    assign prev_size = prev_reg[2*OW-1:OW];
    assign prev_free = prev_reg[2*OW];
    assign n_cur     = segn_reg[pg_reg];
    assign idx_inc   = idx_reg + CW'(1);
    assign j_inc     = j_reg + CW'(1);
    assign j_dec     = j_reg - CW'(1);
    assign need_x    = XW'(need_reg);
    assign e_size_x  = XW'(e_size);
    assign need_w    = NW'({1'b0, req.req_size} + NW'(7)) & ~NW'(7);
    assign off_sel   = (state_reg == S_A_CHK) ? e_off : cur_off;
    assign addr_full = base_reg + BW'(off_sel) + BW'(BLOCK_HDR);
    assign fa_b      = BW'(fa_reg);
    assign base_end  = base_reg + PB_B;

    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = rsp_valid_reg;
    assign rsp.ok           = rsp_ok_reg;
    assign rsp.addr         = rsp_addr_reg;
    assign rsp.pages_in_use = ffba_pkg::PAGES_W'(rsp_pages_reg);
    assign rsp.free_blocks  = rsp_free_reg;
    assign rsp.used_blocks  = rsp_used_reg;

    always_comb
    begin
        state_next      = state_reg;
        page_count_next = page_count_reg;
        pc_base_next    = pc_base_reg;
        free_cnt_next   = free_cnt_reg;
        used_cnt_next   = used_cnt_reg;
        segn_next       = segn_reg;
        rsp_valid_next  = rsp_valid_reg;
        nm_next         = nm_reg;
        rm_last_next    = rm_last_reg;
        need_next       = need_reg;
        fa_next         = fa_reg;
        pg_next         = pg_reg;
        base_next       = base_reg;
        idx_next        = idx_reg;
        j_next          = j_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        foff_next       = foff_reg;
        ok_next         = ok_reg;
        res_addr_next   = res_addr_reg;
        rsp_ok_next     = rsp_ok_reg;
        rsp_addr_next   = rsp_addr_reg;
        rsp_pages_next  = rsp_pages_reg;
        rsp_free_next   = rsp_free_reg;
        rsp_used_next   = rsp_used_reg;
        mem_we          = 1'b0;
        mem_waddr       = seg_addr(pg_reg, idx_reg);
        mem_wdata       = cur_reg;
        mem_re          = 1'b0;
        mem_raddr       = seg_addr(pg_reg, idx_reg);

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    ok_next       = 1'b0;
                    res_addr_next = '0;
                    idx_next      = '0;
                    need_next     = need_w;
                    fa_next       = req.free_addr;
                    if (req.cmd == ffba_pkg::CMD_ALLOC)
                    begin
                        if (XW'(need_w) > CAP_X)
                        begin
                            state_next = S_DONE;
                        end
                        else if (page_count_reg == '0)
                        begin
                            state_next = S_NEWPG;
                        end
                        else
                        begin
                            pg_next    = PW'(page_count_reg - PCW'(1));
                            base_next  = pc_base_reg - PB_B;
                            state_next = S_A_ISS;
                        end
                    end
                    else
                    begin
                        pg_next   = '0;
                        base_next = '0;
                        if (req.free_addr == '0 || page_count_reg == '0)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_F_PG;
                        end
                    end
                end
            end

            S_A_ISS:
            begin
                mem_re     = 1'b1;
                state_next = S_A_CHK;
            end

            S_A_CHK:
            begin
                cur_next = mem_rdata;
                if (e_free && e_size_x >= need_x)
                begin
                    if (e_size_x >= need_x + SPLIT_X && n_cur < CW'(SEGS_PER_PAGE))
                    begin
                        j_next     = n_cur - CW'(1);
                        state_next = S_MV_CHK;
                    end
                    else
                    begin
                        mem_we        = 1'b1;
                        mem_wdata     = {1'b0, e_size, e_off};
                        free_cnt_next = free_cnt_reg - KW'(1);
                        used_cnt_next = used_cnt_reg + KW'(1);
                        ok_next       = 1'b1;
                        res_addr_next = addr_full[ADW-1:0];
                        state_next    = S_DONE;
                    end
                end
                else if (idx_inc < n_cur)
                begin
                    idx_next   = idx_inc;
                    state_next = S_A_ISS;
                end
                else if (pg_reg != '0)
                begin
                    pg_next    = pg_reg - PW'(1);
                    base_next  = base_reg - PB_B;
                    idx_next   = '0;
                    state_next = S_A_ISS;
                end
                else if (page_count_reg < PCW'(MAX_PAGES))
                begin
                    state_next = S_NEWPG;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_NEWPG:
            begin
                mem_we    = 1'b1;
                mem_waddr = seg_addr(PW'(page_count_reg), '0);
                mem_wdata = {1'b1, OW'(PAGE_BYTES - PAGE_HDR), OW'(PAGE_HDR)};
                segn_next[PW'(page_count_reg)] = CW'(1);
                page_count_next = page_count_reg + PCW'(1);
                pc_base_next    = pc_base_reg + PB_B;
                free_cnt_next   = free_cnt_reg + KW'(1);
                pg_next         = PW'(page_count_reg);
                base_next       = pc_base_reg;
                idx_next        = '0;
                state_next      = S_A_ISS;
            end

            S_MV_CHK:
            begin
                if (j_reg > idx_reg)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = seg_addr(pg_reg, j_reg);
                    state_next = S_MV_WR;
                end
                else
                begin
                    state_next = S_SPLIT_HI;
                end
            end

            S_MV_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = seg_addr(pg_reg, j_inc);
                mem_wdata  = mem_rdata;
                j_next     = j_dec;
                state_next = S_MV_CHK;
            end

            S_SPLIT_HI:
            begin
                mem_we     = 1'b1;
                mem_waddr  = seg_addr(pg_reg, idx_inc);
                mem_wdata  = {1'b1,
                              OW'(XW'(cur_size) - need_x - HDR_X),
                              OW'(XW'(cur_off) + HDR_X + need_x)};
                state_next = S_SPLIT_LO;
            end

            S_SPLIT_LO:
            begin
                mem_we             = 1'b1;
                mem_wdata          = {1'b0, OW'(need_reg), cur_off};
                segn_next[pg_reg]  = n_cur + CW'(1);
                used_cnt_next      = used_cnt_reg + KW'(1);
                ok_next            = 1'b1;
                res_addr_next      = addr_full[ADW-1:0];
                state_next         = S_DONE;
            end

            S_F_PG:
            begin
                if (fa_b < base_end)
                begin
                    foff_next  = OW'(fa_b - base_reg);
                    idx_next   = '0;
                    state_next = S_F_ISS;
                end
                else if (PCW'(pg_reg) + PCW'(1) >= page_count_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    pg_next   = pg_reg + PW'(1);
                    base_next = base_end;
                end
            end

            S_F_ISS:
            begin
                mem_re     = 1'b1;
                state_next = S_F_CHK;
            end

            S_F_CHK:
            begin
                if (XW'(e_off) + HDR_X == XW'(foff_reg))
                begin
                    if (e_free)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cur_next      = {1'b1, e_size, e_off};
                        used_cnt_next = used_cnt_reg - KW'(1);
                        free_cnt_next = free_cnt_reg + KW'(1);
                        ok_next       = 1'b1;
                        nm_next       = 1'b0;
                        state_next    = (idx_inc < n_cur) ? S_F_NISS : S_F_WCUR;
                    end
                end
                else
                begin
                    prev_next = mem_rdata;
                    if (idx_inc < n_cur)
                    begin
                        idx_next   = idx_inc;
                        state_next = S_F_ISS;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_F_NISS:
            begin
                mem_re     = 1'b1;
                mem_raddr  = seg_addr(pg_reg, idx_inc);
                state_next = S_F_NCHK;
            end

            S_F_NCHK:
            begin
                if (e_free)
                begin
                    cur_next      = {1'b1, OW'(XW'(cur_size) + HDR_X + e_size_x), cur_off};
                    free_cnt_next = free_cnt_reg - KW'(1);
                    nm_next       = 1'b1;
                end
                state_next = S_F_WCUR;
            end

            S_F_WCUR:
            begin
                mem_we = 1'b1;
                if (nm_reg)
                begin
                    j_next       = idx_inc + CW'(1);
                    rm_last_next = 1'b0;
                    state_next   = S_RM_CHK;
                end
                else
                begin
                    state_next = S_F_PREV;
                end
            end

            S_F_PREV:
            begin
                if (idx_reg != '0 && prev_free)
                begin
                    mem_we        = 1'b1;
                    mem_waddr     = seg_addr(pg_reg, idx_reg - CW'(1));
                    mem_wdata     = {1'b1,
                                     OW'(XW'(prev_size) + HDR_X + XW'(cur_size)),
                                     prev_off};
                    free_cnt_next = free_cnt_reg - KW'(1);
                    j_next        = idx_inc;
                    rm_last_next  = 1'b1;
                    state_next    = S_RM_CHK;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_RM_CHK:
            begin
                if (j_reg < n_cur)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = seg_addr(pg_reg, j_reg);
                    state_next = S_RM_WR;
                end
                else
                begin
                    segn_next[pg_reg] = n_cur - CW'(1);
                    state_next        = rm_last_reg ? S_DONE : S_F_PREV;
                end
            end

            S_RM_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = seg_addr(pg_reg, j_dec);
                mem_wdata  = mem_rdata;
                j_next     = j_inc;
                state_next = S_RM_CHK;
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_ok_next    = ok_reg;
                    rsp_addr_next  = res_addr_reg;
                    rsp_pages_next = page_count_reg;
                    rsp_free_next  = free_cnt_reg;
                    rsp_used_next  = used_cnt_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            page_count_reg <= '0;
            pc_base_reg    <= '0;
            free_cnt_reg   <= '0;
            used_cnt_reg   <= '0;
            rsp_valid_reg  <= 1'b0;
            nm_reg         <= 1'b0;
            rm_last_reg    <= 1'b0;
            for (int k = 0; k < MAX_PAGES; k++)
            begin
                segn_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            page_count_reg <= page_count_next;
            pc_base_reg    <= pc_base_next;
            free_cnt_reg   <= free_cnt_next;
            used_cnt_reg   <= used_cnt_next;
            rsp_valid_reg  <= rsp_valid_next;
            nm_reg         <= nm_next;
            rm_last_reg    <= rm_last_next;
            segn_reg       <= segn_next;
        end
    end

    always_ff @(posedge clk)
    begin
        need_reg      <= need_next;
        fa_reg        <= fa_next;
        pg_reg        <= pg_next;
        base_reg      <= base_next;
        idx_reg       <= idx_next;
        j_reg         <= j_next;
        cur_reg       <= cur_next;
        prev_reg      <= prev_next;
        foff_reg      <= foff_next;
        ok_reg        <= ok_next;
        res_addr_reg  <= res_addr_next;
        rsp_ok_reg    <= rsp_ok_next;
        rsp_addr_reg  <= rsp_addr_next;
        rsp_pages_reg <= rsp_pages_next;
        rsp_free_reg  <= rsp_free_next;
        rsp_used_reg  <= rsp_used_next;
    end

    `FFBA_AST_IMP(a_pages_max, 1'b1, page_count_reg <= PCW'(MAX_PAGES), "page count over max")
    `FFBA_AST_NXT(a_busy_after_beat, req.valid && req.ready, state_reg != S_IDLE, "idle after beat")
    `FFBA_AST_IMP(a_wr_claimed, mem_we && state_reg != S_NEWPG, PCW'(mem_waddr[AW-1:SW]) < page_count_reg, "write to unclaimed page")
    `FFBA_AST_IMP(a_segn_bound, state_reg == S_A_CHK, n_cur <= CW'(SEGS_PER_PAGE) && n_cur != '0, "segment count out of range")

endmodule
